### hdl/rse_pkg.sv
// Package for the RPN stack evaluator: sizes, token codes, flag positions,
// controller/datapath command and status types, fixed-point helper functions.
// No dependencies.
package rse_pkg;

  localparam int VALUE_W     = 32;
  localparam int FRAC_BITS   = 16;
  localparam int MAG_W       = VALUE_W + FRAC_BITS;
  localparam int STACK_DEPTH = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int OP_W        = 3;
  localparam int NUM_FLAGS   = 4;
  localparam int OUT_DATA_W  = 40;

  localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd4;

  localparam int FLAG_UNDER = 0;
  localparam int FLAG_OVER  = 1;
  localparam int FLAG_DIV0  = 2;
  localparam int FLAG_SAT   = 3;

  localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef struct packed {
    logic take;
    logic rd;
    logic exec;
    logic mul_commit;
    logic div_commit;
    logic finish;
  } rse_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            last;
    logic            div_zero;
    logic            div_done;
  } rse_status_t;

  typedef struct packed {
    logic               sat;
    logic [VALUE_W-1:0] value;
  } rse_res_t;

  function automatic logic [VALUE_W-1:0] mag_of(input logic [VALUE_W-1:0] v);
    return v[VALUE_W-1] ? (~v + VALUE_W'(1)) : v;
  endfunction

  // sign + magnitude back to two's complement, clamped to the value range
  function automatic rse_res_t from_mag(input logic neg, input logic [MAG_W-1:0] mag,
                                        input logic ovf);
    rse_res_t         r;
    logic [MAG_W-1:0] lim;
    lim = neg ? MAG_W'(VALUE_MIN) : MAG_W'(VALUE_MAX);
    if (ovf || (mag > lim)) begin
      r.sat   = 1'b1;
      r.value = neg ? VALUE_MIN : VALUE_MAX;
    end else begin
      r.sat   = 1'b0;
      r.value = neg ? (~mag[VALUE_W-1:0] + VALUE_W'(1)) : mag[VALUE_W-1:0];
    end
    return r;
  endfunction

endpackage

### hdl/rse_divider.sv
// Restoring divider, one quotient bit per cycle, for Q16.16 magnitudes.
// Depends on rse_pkg.
module rse_divider
  import rse_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [VALUE_W-1:0] dividend,
  input  logic [VALUE_W-1:0] divisor,
  output logic               done,
  output logic [VALUE_W-1:0] quotient,
  output logic               ovf
);

  localparam int STEP_W = $clog2(VALUE_W);

  logic               busy;
  logic [STEP_W-1:0]  step;
  logic [VALUE_W-1:0] rem;
  logic [VALUE_W-1:0] src;
  logic [VALUE_W-1:0] quo;
  logic [VALUE_W:0]   trial;
  logic               ge;
  logic [VALUE_W-1:0] rem_next;
  logic               early_ovf;

  // quotient reaches 2^32 exactly when the integer part of the dividend >= divisor
  assign early_ovf = VALUE_W'(dividend[VALUE_W-1:FRAC_BITS]) >= divisor;
  assign trial     = {rem, src[VALUE_W-1]};
  assign ge        = trial >= {1'b0, divisor};
  assign rem_next  = ge ? VALUE_W'(trial - {1'b0, divisor}) : trial[VALUE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        step <= '0;
        busy <= !early_ovf;
        done <= early_ovf;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(VALUE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ovf <= early_ovf;
      rem <= VALUE_W'(dividend[VALUE_W-1:FRAC_BITS]);
      src <= {dividend[FRAC_BITS-1:0], {(VALUE_W-FRAC_BITS){1'b0}}};
      quo <= '0;
    end else if (busy) begin
      rem <= rem_next;
      src <= {src[VALUE_W-2:0], 1'b0};
      quo <= {quo[VALUE_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

### hdl/rse_datapath.sv
// Datapath: token register, value stack memory with cached top, arithmetic,
// sticky flags and result register. Depends on rse_pkg and rse_divider.
module rse_datapath
  import rse_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  rse_cmd_t           cmd,
  output rse_status_t        status,
  input  logic [OP_W-1:0]    in_opcode,
  input  logic [VALUE_W-1:0] in_value,
  input  logic               in_last,
  output logic [VALUE_W-1:0] answer,
  output logic               stack_was_empty,
  output logic [NUM_FLAGS-1:0] flags_out
);

  logic [VALUE_W-1:0]   stack_mem [STACK_DEPTH];
  logic [CNT_W-1:0]     count;
  logic [NUM_FLAGS-1:0] flags;
  logic [VALUE_W-1:0]   tos;
  logic [VALUE_W-1:0]   rd_data;
  logic [OP_W-1:0]      tok_op;
  logic [VALUE_W-1:0]   tok_val;
  logic                 tok_last;
  logic [2*VALUE_W-1:0] prod;
  logic                 res_neg;

  logic                 has_one;
  logic                 has_two;
  logic                 is_arith;
  logic                 is_addsub;
  logic                 stack_full;
  logic [VALUE_W-1:0]   right;
  logic [VALUE_W-1:0]   left;
  logic [VALUE_W-1:0]   left_mag;
  logic [VALUE_W-1:0]   right_mag;
  logic [VALUE_W:0]     sum;
  rse_res_t             addsub_res;
  rse_res_t             mul_res;
  rse_res_t             div_res;
  logic [CNT_W-1:0]     cnt_after_op;
  logic [CNT_W-1:0]     cnt_m1;
  logic [CNT_W-1:0]     cnt_m2;
  logic                 div_start;
  logic                 div_done;
  logic                 div_ovf;
  logic [VALUE_W-1:0]   quotient;

  assign has_one    = count != '0;
  assign has_two    = count > CNT_W'(1);
  assign stack_full = count == CNT_W'(STACK_DEPTH);
  assign is_arith   = (tok_op >= OP_ADD) && (tok_op <= OP_DIV);
  assign is_addsub  = (tok_op == OP_ADD) || (tok_op == OP_SUB);
  assign cnt_m1     = count - CNT_W'(1);
  assign cnt_m2     = count - CNT_W'(2);

  assign right     = has_one ? tos : '0;
  assign left      = has_two ? rd_data : '0;
  assign left_mag  = mag_of(left);
  assign right_mag = mag_of(right);

  assign cnt_after_op = (has_two ? cnt_m2 : '0) + CNT_W'(1);

  always_comb begin
    if (tok_op == OP_SUB) begin
      sum = {left[VALUE_W-1], left} - {right[VALUE_W-1], right};
    end else begin
      sum = {left[VALUE_W-1], left} + {right[VALUE_W-1], right};
    end
    if (sum[VALUE_W] != sum[VALUE_W-1]) begin
      addsub_res.sat   = 1'b1;
      addsub_res.value = sum[VALUE_W] ? VALUE_MIN : VALUE_MAX;
    end else begin
      addsub_res.sat   = 1'b0;
      addsub_res.value = sum[VALUE_W-1:0];
    end
  end

  assign mul_res = from_mag(res_neg, prod[2*VALUE_W-1:FRAC_BITS], 1'b0);
  assign div_res = from_mag(res_neg, MAG_W'(quotient), div_ovf);

  assign div_start = cmd.exec && (tok_op == OP_DIV) && (right != '0);

  rse_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (left_mag),
    .divisor  (right_mag),
    .done     (div_done),
    .quotient (quotient),
    .ovf      (div_ovf)
  );

  assign status.op       = tok_op;
  assign status.last     = tok_last;
  assign status.div_zero = right == '0;
  assign status.div_done = div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      flags <= '0;
    end else if (cmd.exec) begin
      if (tok_op == OP_PUSH) begin
        if (stack_full) begin
          flags[FLAG_OVER] <= 1'b1;
        end else begin
          count <= count + CNT_W'(1);
        end
      end else if (is_arith) begin
        count <= cnt_after_op;
        flags[FLAG_UNDER] <= flags[FLAG_UNDER] | !has_two;
        flags[FLAG_SAT]   <= flags[FLAG_SAT] | (is_addsub && addsub_res.sat);
        flags[FLAG_DIV0]  <= flags[FLAG_DIV0] | ((tok_op == OP_DIV) && (right == '0));
      end
    end else if (cmd.mul_commit) begin
      flags[FLAG_SAT] <= flags[FLAG_SAT] | mul_res.sat;
    end else if (cmd.div_commit) begin
      flags[FLAG_SAT] <= flags[FLAG_SAT] | div_res.sat;
    end else if (cmd.finish) begin
      count <= '0;
      flags <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      tok_op   <= in_opcode;
      tok_val  <= in_value;
      tok_last <= in_last;
    end
    if (cmd.rd) begin
      rd_data <= stack_mem[cnt_m2[ADDR_W-1:0]];
    end
    if (cmd.exec) begin
      res_neg <= left[VALUE_W-1] ^ right[VALUE_W-1];
      if (tok_op == OP_PUSH) begin
        if (!stack_full) begin
          if (has_one) begin
            stack_mem[cnt_m1[ADDR_W-1:0]] <= tos;
          end
          tos <= tok_val;
        end
      end else if (is_addsub) begin
        tos <= addsub_res.value;
      end else if (tok_op == OP_MUL) begin
        prod <= left_mag * right_mag;
      end else if ((tok_op == OP_DIV) && (right == '0)) begin
        tos <= left[VALUE_W-1] ? VALUE_MIN : VALUE_MAX;
      end
    end
    if (cmd.mul_commit) begin
      tos <= mul_res.value;
    end
    if (cmd.div_commit) begin
      tos <= div_res.value;
    end
    if (cmd.finish) begin
      answer          <= has_one ? tos : '0;
      stack_was_empty <= !has_one;
      flags_out       <= flags;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (count == '0) && (flags == '0))
    else $error("stack not cleared after expression end");

  a_full_push_flags: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && (tok_op == OP_PUSH) && stack_full) |=> flags[FLAG_OVER] && stack_full)
    else $error("dropped push not flagged");
`endif

endmodule

### hdl/rse_ctrl.sv
// Controller for the RPN stack evaluator: token sequencing, handshakes and
// result valid. Depends on rse_pkg.
module rse_ctrl
  import rse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output rse_cmd_t    cmd,
  input  rse_status_t status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_FIN
  } state_t;

  state_t state;

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: cmd.take       = in_valid;
      S_READ: cmd.rd         = 1'b1;
      S_EXEC: cmd.exec       = 1'b1;
      S_MUL:  cmd.mul_commit = 1'b1;
      S_DIV:  cmd.div_commit = status.div_done;
      S_FIN:  cmd.finish     = status.last && (!out_valid || out_ready);
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (in_valid) state <= S_READ;
        S_READ: state <= S_EXEC;
        S_EXEC: begin
          if (status.op == OP_MUL) begin
            state <= S_MUL;
          end else if ((status.op == OP_DIV) && !status.div_zero) begin
            state <= S_DIV;
          end else begin
            state <= S_FIN;
          end
        end
        S_MUL: state <= S_FIN;
        S_DIV: if (status.div_done) state <= S_FIN;
        S_FIN: if (!status.last || cmd.finish) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.take, cmd.rd, cmd.exec, cmd.mul_commit, cmd.div_commit, cmd.finish}))
    else $error("more than one datapath command");

  a_div_to_fin: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) && status.div_done |=> state == S_FIN)
    else $error("divide completion missed");

  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid && (state == S_IDLE))
    else $error("result not presented after expression end");
`endif

endmodule

### hdl/rpn_stack_evaluator_unit.sv
// Top level of the RPN stack evaluator: stream ports, controller, datapath.
// Depends on rse_pkg, rse_ctrl, rse_datapath.
//
// Evaluates reverse Polish expressions on signed Q16.16 values, one token per
// input transfer, with a 32-entry stack. Tokens are handled one at a time: each
// is taken, the stack is read and the token executes; a multiply then commits
// its product, and a divide by a nonzero value waits for the divider, which
// produces one quotient bit per cycle (it stops early when the quotient is known
// to saturate). The token with tlast set holds in its finish state for as long
// as the previous result still waits in the output register; otherwise the next
// token is taken while a result waits. Each expression yields one output
// transfer carrying the top of stack and the sticky error flags.
module rpn_stack_evaluator_unit
  import rse_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [VALUE_W-1:0]    s_axis_tdata,  // [31:0] operand_value
  input  logic [OP_W-1:0]       s_axis_tuser,  // [2:0] opcode
  input  logic                  s_axis_tlast,  // end_of_expression
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [31:0] answer, [32] stack_was_empty, [33] underflow_seen, [34] overflow_seen,
  // [35] divide_by_zero_seen, [36] saturation_seen, [39:37] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  rse_cmd_t             cmd;
  rse_status_t          status;
  logic [VALUE_W-1:0]   answer;
  logic                 stack_was_empty;
  logic [NUM_FLAGS-1:0] flags_out;

  rse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .status    (status)
  );

  rse_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .in_opcode       (s_axis_tuser),
    .in_value        (s_axis_tdata),
    .in_last         (s_axis_tlast),
    .answer          (answer),
    .stack_was_empty (stack_was_empty),
    .flags_out       (flags_out)
  );

  assign m_axis_tdata = {{(OUT_DATA_W-VALUE_W-NUM_FLAGS-1){1'b0}},
                         flags_out[FLAG_SAT], flags_out[FLAG_DIV0],
                         flags_out[FLAG_OVER], flags_out[FLAG_UNDER],
                         stack_was_empty, answer};

endmodule
